// File: hdl/slle_pkg.sv
package slle_pkg;

    // Table geometry: slot 0 heads the free chain, the last slot heads the data list.
    localparam int TABLE_SLOTS = 32;
    localparam int IDX_W       = $clog2(TABLE_SLOTS);
    localparam int CNT_W       = $clog2(TABLE_SLOTS);
    localparam int MAX_RESULTS = 30;
    localparam int K_W         = $clog2(MAX_RESULTS);

    // Field widths.
    localparam int ACT_W  = 2;
    localparam int POS_W  = 6;
    localparam int DATA_W = 32;
    localparam int STAT_W = 2;
    localparam int LEN_W  = 5;

    localparam logic [IDX_W-1:0] FREE_SLOT = '0;
    localparam logic [IDX_W-1:0] HEAD_SLOT = IDX_W'(TABLE_SLOTS - 1);

    // Operation codes.
    localparam logic [ACT_W-1:0] ACT_INSERT   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_DELETE   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_TRAVERSE = 2'd2;

    // Result status codes.
    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_BAD_POS = 2'd1;
    localparam logic [STAT_W-1:0] ST_NO_FREE = 2'd2;

endpackage

// File: hdl/slle_ram.sv
module slle_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // One write port and one registered read port; read data holds between reads.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: hdl/static_linked_list_engine.sv
// Array-based singly linked list engine.
// The slave stream carries one command per transfer: the operation in tuser
// (insert before a one-based position, delete at a position, traverse), the
// position and the insert value in tdata. The master stream returns results:
// status in tuser, the element and the list length in tdata, and tlast on the
// final result of a command. Insert and delete give one result; a traverse
// gives one result per element (at most 30), or one result on an empty list.
// Commands are handled one at a time by a small sequencer that reads the link
// table once per cycle. An insert that finds a free node, or a delete, at
// position p walks p - 1 links from the head slot before it relinks; a bad
// position or unknown action goes straight to its result. A traverse hands
// over its results one by one as it follows the links. The sequencer returns
// to idle in the same cycle that the final result of a command is registered.
// tready on the slave side is high only while the sequencer is idle. The
// results sit in an output register, so the next command is accepted while
// the last result still waits; a stalled receiver holds the sequencer only
// at the point where it must hand over a further result.
// Reset builds the free chain 1, 2, ... in the link table, empties the list
// and clears the output valid flag; the data table is read only at written slots.
module static_linked_list_engine
    import slle_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [39:0] i_s_axis_tdata,   // position [5:0], value [37:6], zero pad
    input  logic [1:0]  i_s_axis_tuser,   // action [1:0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,   // element [31:0], length [36:32], zero pad
    output logic [1:0]  o_m_axis_tuser,   // status [1:0]
    output logic        o_m_axis_tlast
);

    localparam int CMP_W = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

    // Sequencer states.
    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_INS_FREE  = 4'd1;
    localparam logic [3:0] S_INS_UNL   = 4'd2;
    localparam logic [3:0] S_WALK      = 4'd3;
    localparam logic [3:0] S_INS_LINK1 = 4'd4;
    localparam logic [3:0] S_INS_LINK2 = 4'd5;
    localparam logic [3:0] S_DEL_CHK   = 4'd6;
    localparam logic [3:0] S_DEL1      = 4'd7;
    localparam logic [3:0] S_DEL2      = 4'd8;
    localparam logic [3:0] S_DEL3      = 4'd9;
    localparam logic [3:0] S_RESP      = 4'd10;
    localparam logic [3:0] S_TRV_START = 4'd11;
    localparam logic [3:0] S_TRV_RD    = 4'd12;
    localparam logic [3:0] S_TRV_OUT   = 4'd13;

    logic [3:0]        r_state, n_state;
    logic [IDX_W-1:0]  r_link [TABLE_SLOTS];
    logic [CNT_W-1:0]  r_count, n_count;
    logic [ACT_W-1:0]  r_act, n_act;
    logic [POS_W-1:0]  r_steps, n_steps;
    logic [DATA_W-1:0] r_value, n_value;
    logic [IDX_W-1:0]  r_cur, n_cur;
    logic [IDX_W-1:0]  r_node, n_node;
    logic [IDX_W-1:0]  r_nxt, n_nxt;
    logic              r_fin, n_fin;
    logic [K_W-1:0]    r_k, n_k;
    logic [STAT_W-1:0] r_status, n_status;

    logic              r_out_valid, n_out_valid;
    logic [STAT_W-1:0] r_out_status, n_out_status;
    logic [DATA_W-1:0] r_out_elem, n_out_elem;
    logic              r_out_last, n_out_last;
    logic [LEN_W-1:0]  r_out_len, n_out_len;

    logic [IDX_W-1:0]  rd_idx;
    logic [IDX_W-1:0]  link_rd;
    logic              lk_wr_en;
    logic [IDX_W-1:0]  lk_wr_idx;
    logic [IDX_W-1:0]  lk_wr_val;
    logic              ram_wr_en;
    logic              ram_rd_en;
    logic [DATA_W-1:0] ram_rd_data;
    logic              out_free;
    logic              in_xfer;
    logic [POS_W-1:0]  in_pos;
    logic              ins_pos_ok;
    logic              del_pos_ok;

    assign in_pos     = i_s_axis_tdata[POS_W-1:0];
    assign in_xfer    = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free   = !r_out_valid || i_m_axis_tready;
    assign ins_pos_ok = (in_pos != '0) &&
                        (CMP_W'(in_pos) <= CMP_W'(r_count) + CMP_W'(1));
    assign del_pos_ok = (in_pos != '0) && (CMP_W'(in_pos) <= CMP_W'(r_count));

    // Single link table read port; the sequencer picks the slot.
    assign link_rd = r_link[rd_idx];

    // Data table.
    slle_ram #(
        .WIDTH (DATA_W),
        .DEPTH (TABLE_SLOTS)
    ) u_data_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (r_node),
        .i_wr_data (r_value),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (r_cur),
        .o_rd_data (ram_rd_data)
    );

    // Sequencer: one link read and at most one link write per cycle.
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_act        = r_act;
        n_steps      = r_steps;
        n_value      = r_value;
        n_cur        = r_cur;
        n_node       = r_node;
        n_nxt        = r_nxt;
        n_fin        = r_fin;
        n_k          = r_k;
        n_status     = r_status;
        n_out_valid  = r_out_valid && !i_m_axis_tready;
        n_out_status = r_out_status;
        n_out_elem   = r_out_elem;
        n_out_last   = r_out_last;
        n_out_len    = r_out_len;
        rd_idx       = r_cur;
        lk_wr_en     = 1'b0;
        lk_wr_idx    = r_cur;
        lk_wr_val    = '0;
        ram_wr_en    = 1'b0;
        ram_rd_en    = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_act    = i_s_axis_tuser;
                    n_value  = i_s_axis_tdata[POS_W+DATA_W-1:POS_W];
                    n_steps  = in_pos - POS_W'(1);
                    n_cur    = HEAD_SLOT;
                    n_status = ST_OK;
                    unique case (i_s_axis_tuser)
                        ACT_INSERT: begin
                            if (ins_pos_ok) begin
                                n_state = S_INS_FREE;
                            end else begin
                                n_status = ST_BAD_POS;
                                n_state  = S_RESP;
                            end
                        end
                        ACT_DELETE: begin
                            if (del_pos_ok) begin
                                n_state = S_WALK;
                            end else begin
                                n_status = ST_BAD_POS;
                                n_state  = S_RESP;
                            end
                        end
                        ACT_TRAVERSE: begin
                            n_k     = '0;
                            n_state = S_TRV_START;
                        end
                        default: begin
                            n_status = ST_BAD_POS;
                            n_state  = S_RESP;
                        end
                    endcase
                end
            end
            S_INS_FREE: begin
                // Take the first free node, if any.
                rd_idx = FREE_SLOT;
                n_node = link_rd;
                if (link_rd == FREE_SLOT || link_rd >= HEAD_SLOT) begin
                    n_status = ST_NO_FREE;
                    n_state  = S_RESP;
                end else begin
                    n_state = S_INS_UNL;
                end
            end
            S_INS_UNL: begin
                // Unlink the node from the free chain and store the value.
                rd_idx    = r_node;
                lk_wr_en  = 1'b1;
                lk_wr_idx = FREE_SLOT;
                lk_wr_val = link_rd;
                ram_wr_en = 1'b1;
                n_state   = S_WALK;
            end
            S_WALK: begin
                // Step toward the slot in front of the target position.
                rd_idx = r_cur;
                if (r_steps != '0) begin
                    n_cur   = link_rd;
                    n_steps = r_steps - POS_W'(1);
                end else if (r_act == ACT_INSERT) begin
                    n_state = S_INS_LINK1;
                end else begin
                    n_state = S_DEL_CHK;
                end
            end
            S_INS_LINK1: begin
                rd_idx    = r_cur;
                lk_wr_en  = 1'b1;
                lk_wr_idx = r_node;
                lk_wr_val = link_rd;
                n_state   = S_INS_LINK2;
            end
            S_INS_LINK2: begin
                lk_wr_en  = 1'b1;
                lk_wr_idx = r_cur;
                lk_wr_val = r_node;
                n_count   = r_count + CNT_W'(1);
                n_state   = S_RESP;
            end
            S_DEL_CHK: begin
                rd_idx = r_cur;
                n_node = link_rd;
                if (link_rd != FREE_SLOT && link_rd < HEAD_SLOT) begin
                    n_state = S_DEL1;
                end else begin
                    n_state = S_RESP;
                end
            end
            S_DEL1: begin
                // Bridge the list over the removed node.
                rd_idx    = r_node;
                lk_wr_en  = 1'b1;
                lk_wr_idx = r_cur;
                lk_wr_val = link_rd;
                n_state   = S_DEL2;
            end
            S_DEL2: begin
                // The removed node points at the old free head.
                rd_idx    = FREE_SLOT;
                lk_wr_en  = 1'b1;
                lk_wr_idx = r_node;
                lk_wr_val = link_rd;
                n_state   = S_DEL3;
            end
            S_DEL3: begin
                lk_wr_en  = 1'b1;
                lk_wr_idx = FREE_SLOT;
                lk_wr_val = r_node;
                n_count   = r_count - CNT_W'(1);
                n_state   = S_RESP;
            end
            S_RESP: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_elem   = '0;
                    n_out_last   = 1'b1;
                    n_out_len    = LEN_W'(r_count);
                    n_state      = S_IDLE;
                end
            end
            S_TRV_START: begin
                rd_idx = HEAD_SLOT;
                n_cur  = link_rd;
                if (r_count == '0 || link_rd == FREE_SLOT) begin
                    n_status = ST_BAD_POS;
                    n_state  = S_RESP;
                end else begin
                    n_state = S_TRV_RD;
                end
            end
            S_TRV_RD: begin
                // Fetch the datum and look ahead at the next link.
                rd_idx    = r_cur;
                ram_rd_en = 1'b1;
                n_nxt     = link_rd;
                n_fin     = (link_rd == FREE_SLOT) || (r_k == K_W'(MAX_RESULTS - 1));
                n_state   = S_TRV_OUT;
            end
            S_TRV_OUT: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = ST_OK;
                    n_out_elem   = ram_rd_data;
                    n_out_last   = r_fin;
                    n_out_len    = LEN_W'(r_count);
                    if (r_fin) begin
                        n_state = S_IDLE;
                    end else begin
                        n_cur   = r_nxt;
                        n_k     = r_k + K_W'(1);
                        n_state = S_TRV_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers and the link table, which reset builds into the free chain.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            for (int s = 0; s < TABLE_SLOTS; s++) begin
                r_link[s] <= (s < TABLE_SLOTS - 2) ? IDX_W'(s + 1) : '0;
            end
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            if (lk_wr_en) begin
                r_link[lk_wr_idx] <= lk_wr_val;
            end
        end
    end

    // Working and payload registers.
    always_ff @(posedge i_clk) begin
        r_act        <= n_act;
        r_steps      <= n_steps;
        r_value      <= n_value;
        r_cur        <= n_cur;
        r_node       <= n_node;
        r_nxt        <= n_nxt;
        r_fin        <= n_fin;
        r_k          <= n_k;
        r_status     <= n_status;
        r_out_status <= n_out_status;
        r_out_elem   <= n_out_elem;
        r_out_last   <= n_out_last;
        r_out_len    <= n_out_len;
    end

    // Stream ports.
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(40 - DATA_W - LEN_W){1'b0}}, r_out_len, r_out_elem};
    assign o_m_axis_tuser  = r_out_status;
    assign o_m_axis_tlast  = r_out_last;

endmodule
